>>> src/classifier_vote_debouncer_core_defines.svh
// Assertion macros used by the checker of this block.
`ifndef CLASSIFIER_VOTE_DEBOUNCER_CORE_DEFINES_SVH
`define CLASSIFIER_VOTE_DEBOUNCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVD_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cvd_pkg.sv
package cvd_pkg;

  localparam int SCORE_W  = 16;
  localparam int FRAMES_W = 6;
  localparam int IDX_W    = 2;
  localparam int ACTIVE_W = 3;
  localparam int MAX_LABELS = 4;

  localparam logic [SCORE_W-1:0]  IDLE_THRESHOLD = 16'd16384;
  localparam logic [ACTIVE_W-1:0] LABEL_NONE     = 3'd4;
  localparam logic [FRAMES_W-1:0] RUN_MAX        = 6'd63;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEFAULT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_TAP_THRESHOLD     = 3'd1;
  localparam logic [2:0] REG_SHAKE_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_DEFAULT_FRAMES    = 3'd3;
  localparam logic [2:0] REG_TAP_FRAMES        = 3'd4;
  localparam logic [2:0] REG_SHAKE_FRAMES      = 3'd5;
  localparam logic [2:0] REG_IDLE_FRAMES       = 3'd6;
  localparam logic [2:0] REG_LABEL_KINDS       = 3'd7;

  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_TAP     = 2'd1,
    KIND_SHAKE   = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  default_thr;
    logic [SCORE_W-1:0]  tap_thr;
    logic [SCORE_W-1:0]  shake_thr;
    logic [FRAMES_W-1:0] default_frames;
    logic [FRAMES_W-1:0] tap_frames;
    logic [FRAMES_W-1:0] shake_frames;
    logic [FRAMES_W-1:0] idle_frames;
    logic [7:0]          label_kinds;
  } cfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    kind_t               kind;
    logic                pass;
    logic [FRAMES_W-1:0] frames;
  } lane_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    lane_t            lane;
  } win_t;

  typedef struct packed {
    logic                fired;
    logic [1:0]          event_kind;
    logic [IDX_W-1:0]    winning_label;
    logic [SCORE_W-1:0]  winning_score;
    logic [ACTIVE_W-1:0] active_label;
  } result_t;

endpackage

>>> src/cvd_lane.sv
// One label: looks up its kind and tests its score against that kind's threshold.
module cvd_lane (
  input  logic [cvd_pkg::SCORE_W-1:0] score,
  input  cvd_pkg::kind_t              kind,
  input  cvd_pkg::cfg_t               cfg,
  output cvd_pkg::lane_t              lane
);

  logic [cvd_pkg::SCORE_W-1:0]  thr;
  logic [cvd_pkg::FRAMES_W-1:0] frames;

  // Select threshold and run length by kind.
  always_comb begin
    unique case (kind)
      cvd_pkg::KIND_TAP: begin
        thr    = cfg.tap_thr;
        frames = cfg.tap_frames;
      end
      cvd_pkg::KIND_SHAKE: begin
        thr    = cfg.shake_thr;
        frames = cfg.shake_frames;
      end
      cvd_pkg::KIND_IDLE: begin
        thr    = cvd_pkg::IDLE_THRESHOLD;
        frames = cfg.idle_frames;
      end
      default: begin
        thr    = cfg.default_thr;
        frames = cfg.default_frames;
      end
    endcase
  end

  assign lane.score  = score;
  assign lane.kind   = kind;
  assign lane.pass   = (score >= thr);
  assign lane.frames = frames;

endmodule

>>> src/cvd_merge.sv
// Picks the lane with the highest score; ties go to the lowest index.
module cvd_merge #(
  parameter int LABELS = 4
) (
  input  cvd_pkg::lane_t [LABELS-1:0] lanes,
  output cvd_pkg::win_t               win
);

  always_comb begin
    win.idx  = '0;
    win.lane = lanes[0];
    for (int i = 1; i < LABELS; i++) begin
      if (lanes[i].score > win.lane.score) begin
        win.idx  = cvd_pkg::IDX_W'(i);
        win.lane = lanes[i];
      end
    end
  end

endmodule

>>> src/cvd_out_fifo.sv
// Two-entry result queue, so a new item is taken while a result waits.
module cvd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cvd_pkg::result_t push_data,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output cvd_pkg::result_t head
);

  cvd_pkg::result_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

endmodule

>>> src/classifier_vote_debouncer_core.sv
// Classifier vote debouncer. Each transfer on the input carries one Q1.15
// score per label; LABELS lanes test every label against its kind's threshold
// in parallel, a merge stage picks the highest score (lowest index on ties),
// and the run counter decides whether the active label moves. One item is
// taken every cycle unless the queue is full; its result enters a two-entry
// output queue in the next cycle; input ready drops only while both entries
// wait. The per-frame state update (candidate, run count, active label) is a
// single register stage, which sets the one-item-per-cycle figure.
module classifier_vote_debouncer_core #(
  parameter int LABELS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [cvd_pkg::SCORE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cvd_pkg::SCORE_W-1:0]  score_0,
  input  logic [cvd_pkg::SCORE_W-1:0]  score_1,
  input  logic [cvd_pkg::SCORE_W-1:0]  score_2,
  input  logic [cvd_pkg::SCORE_W-1:0]  score_3,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         fired,
  output logic [1:0]                   event_kind,
  output logic [cvd_pkg::IDX_W-1:0]    winning_label,
  output logic [cvd_pkg::SCORE_W-1:0]  winning_score,
  output logic [cvd_pkg::ACTIVE_W-1:0] active_label
);

  cvd_pkg::cfg_t                  cfg;
  logic [cvd_pkg::SCORE_W-1:0]    scores [cvd_pkg::MAX_LABELS];
  cvd_pkg::lane_t [LABELS-1:0]    lanes;
  cvd_pkg::win_t                  win;
  cvd_pkg::result_t               res;
  cvd_pkg::result_t               head;
  logic                           fifo_full;
  logic                           accept;

  logic [cvd_pkg::ACTIVE_W-1:0]   accepted;
  logic [cvd_pkg::ACTIVE_W-1:0]   accepted_next;
  logic [cvd_pkg::ACTIVE_W-1:0]   candidate;
  logic [cvd_pkg::ACTIVE_W-1:0]   candidate_next;
  logic [cvd_pkg::FRAMES_W-1:0]   run_count;
  logic [cvd_pkg::FRAMES_W-1:0]   run_count_next;
  logic [cvd_pkg::FRAMES_W-1:0]   run_inc;

  assign scores[0] = score_0;
  assign scores[1] = score_1;
  assign scores[2] = score_2;
  assign scores[3] = score_3;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_thr    <= 16'd22938;
      cfg.tap_thr        <= 16'd32113;
      cfg.shake_thr      <= 16'd27853;
      cfg.default_frames <= 6'd5;
      cfg.tap_frames     <= 6'd18;
      cfg.shake_frames   <= 6'd3;
      cfg.idle_frames    <= 6'd4;
      cfg.label_kinds    <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvd_pkg::REG_DEFAULT_THRESHOLD: cfg.default_thr    <= cfg_data;
        cvd_pkg::REG_TAP_THRESHOLD:     cfg.tap_thr        <= cfg_data;
        cvd_pkg::REG_SHAKE_THRESHOLD:   cfg.shake_thr      <= cfg_data;
        cvd_pkg::REG_DEFAULT_FRAMES:    cfg.default_frames <= cfg_data[5:0];
        cvd_pkg::REG_TAP_FRAMES:        cfg.tap_frames     <= cfg_data[5:0];
        cvd_pkg::REG_SHAKE_FRAMES:      cfg.shake_frames   <= cfg_data[5:0];
        cvd_pkg::REG_IDLE_FRAMES:       cfg.idle_frames    <= cfg_data[5:0];
        cvd_pkg::REG_LABEL_KINDS:       cfg.label_kinds    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // One lane per label.
  for (genvar g = 0; g < LABELS; g++) begin : g_lane
    cvd_lane u_lane (
      .score (scores[g]),
      .kind  (cvd_pkg::kind_t'(cfg.label_kinds[2*g +: 2])),
      .cfg   (cfg),
      .lane  (lanes[g])
    );
  end

  cvd_merge #(
    .LABELS (LABELS)
  ) u_merge (
    .lanes (lanes),
    .win   (win)
  );

  assign in_ready = ~fifo_full;
  assign accept   = in_valid & in_ready;

  // Debounce update for the winning label.
  always_comb begin
    accepted_next  = accepted;
    candidate_next = candidate;
    run_count_next = '0;
    run_inc        = '0;
    res.fired      = 1'b0;
    res.event_kind = 2'd0;
    if (win.lane.pass) begin
      if ({1'b0, win.idx} == candidate) begin
        run_inc = (run_count < cvd_pkg::RUN_MAX) ? run_count + 6'd1 : run_count;
      end else begin
        candidate_next = {1'b0, win.idx};
        run_inc        = 6'd1;
      end
      run_count_next = run_inc;
      if (run_inc >= win.lane.frames) begin
        run_count_next = win.lane.frames;
        if (accepted != candidate_next) begin
          accepted_next = candidate_next;
          if (win.lane.kind != cvd_pkg::KIND_DEFAULT) begin
            res.fired      = 1'b1;
            res.event_kind = 2'(win.lane.kind) - 2'd1;
          end
        end
      end
    end
    res.winning_label = win.idx;
    res.winning_score = win.lane.score;
    res.active_label  = accepted_next;
  end

  // Debounce state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= cvd_pkg::LABEL_NONE;
      candidate <= cvd_pkg::LABEL_NONE;
      run_count <= '0;
    end else if (accept) begin
      accepted  <= accepted_next;
      candidate <= candidate_next;
      run_count <= run_count_next;
    end
  end

  cvd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (fifo_full),
    .valid     (out_valid),
    .pop       (out_valid & out_ready),
    .head      (head)
  );

  assign fired         = head.fired;
  assign event_kind    = head.event_kind;
  assign winning_label = head.winning_label;
  assign winning_score = head.winning_score;
  assign active_label  = head.active_label;

endmodule

>>> src/cvd_checker.sv
`include "classifier_vote_debouncer_core_defines.svh"

// Port-level checks on the result stream.
module cvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        fired,
  input logic [1:0]  event_kind,
  input logic [1:0]  winning_label,
  input logic [15:0] winning_score,
  input logic [2:0]  active_label
);

  // A fired event always makes the winner of that frame the active label.
  `CVD_ASSERT_SAME(a_fired_active, out_valid && fired, active_label == {1'b0, winning_label}, "fired without winner becoming active")

  // Without an event the kind field is zero, and a fired kind is never beyond idle.
  `CVD_ASSERT_SAME(a_event_kind, out_valid, (fired || event_kind == 2'd0) && event_kind != 2'd3, "bad event kind")

  // The active label is a real label or the none code.
  `CVD_ASSERT_SAME(a_active_range, out_valid, !active_label[2] || active_label[1:0] == 2'd0, "active label out of range")

  // A stalled result holds.
  `CVD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(winning_score) && $stable(active_label), "stalled result changed")

endmodule

bind classifier_vote_debouncer_core cvd_checker u_cvd_checker (.*);

>>> bench/tb_classifier_vote_debouncer_core.sv
module tb_classifier_vote_debouncer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 10;

  typedef logic [cvd_pkg::MAX_LABELS-1:0][cvd_pkg::SCORE_W-1:0] frame_t;

  typedef enum logic [0:0] {
    ROW_FRAME = 1'b0,
    ROW_WRITE = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    frame_t           scores;
    logic [2:0]       reg_idx;
    logic [15:0]      reg_data;
    bit               typed;
    cvd_pkg::result_t want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [2:0]                   cfg_index = '0;
  logic [cvd_pkg::SCORE_W-1:0]  cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [cvd_pkg::SCORE_W-1:0]  score_0 = '0;
  logic [cvd_pkg::SCORE_W-1:0]  score_1 = '0;
  logic [cvd_pkg::SCORE_W-1:0]  score_2 = '0;
  logic [cvd_pkg::SCORE_W-1:0]  score_3 = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         fired;
  logic [1:0]                   event_kind;
  logic [cvd_pkg::IDX_W-1:0]    winning_label;
  logic [cvd_pkg::SCORE_W-1:0]  winning_score;
  logic [cvd_pkg::ACTIVE_W-1:0] active_label;

  // Mirror of the debouncer: configuration and per-frame state.
  cvd_pkg::cfg_t                cfg_mirror;
  logic [cvd_pkg::ACTIVE_W-1:0] held_label;
  logic [cvd_pkg::ACTIVE_W-1:0] cand_label;
  logic [cvd_pkg::FRAMES_W-1:0] run_len;

  cvd_pkg::result_t pending_results[$];
  stim_row_t        directed_rows[$];
  int               error_count = 0;
  bit               pacing_off = 1'b0;

  classifier_vote_debouncer_core #(
    .LABELS(4)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .score_0      (score_0),
    .score_1      (score_1),
    .score_2      (score_2),
    .score_3      (score_3),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fired        (fired),
    .event_kind   (event_kind),
    .winning_label(winning_label),
    .winning_score(winning_score),
    .active_label (active_label)
  );

  always #5 clk = ~clk;

  // Reset is held at the start only, then released for the rest of the run.
  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Kind, threshold and run length that apply to one label.
  function automatic void lane_setting(input logic [1:0] idx, output cvd_pkg::kind_t k,
                                       output logic [15:0] thr, output logic [5:0] fr);
    k = cvd_pkg::kind_t'(cfg_mirror.label_kinds[2*idx +: 2]);
    case (k)
      cvd_pkg::KIND_TAP: begin
        thr = cfg_mirror.tap_thr;
        fr  = cfg_mirror.tap_frames;
      end
      cvd_pkg::KIND_SHAKE: begin
        thr = cfg_mirror.shake_thr;
        fr  = cfg_mirror.shake_frames;
      end
      cvd_pkg::KIND_IDLE: begin
        thr = cvd_pkg::IDLE_THRESHOLD;
        fr  = cfg_mirror.idle_frames;
      end
      default: begin
        thr = cfg_mirror.default_thr;
        fr  = cfg_mirror.default_frames;
      end
    endcase
  endfunction

  function automatic void mirror_write(logic [2:0] idx, logic [15:0] data);
    case (idx)
      cvd_pkg::REG_DEFAULT_THRESHOLD: cfg_mirror.default_thr    = data;
      cvd_pkg::REG_TAP_THRESHOLD:     cfg_mirror.tap_thr        = data;
      cvd_pkg::REG_SHAKE_THRESHOLD:   cfg_mirror.shake_thr      = data;
      cvd_pkg::REG_DEFAULT_FRAMES:    cfg_mirror.default_frames = data[5:0];
      cvd_pkg::REG_TAP_FRAMES:        cfg_mirror.tap_frames     = data[5:0];
      cvd_pkg::REG_SHAKE_FRAMES:      cfg_mirror.shake_frames   = data[5:0];
      cvd_pkg::REG_IDLE_FRAMES:       cfg_mirror.idle_frames    = data[5:0];
      cvd_pkg::REG_LABEL_KINDS:       cfg_mirror.label_kinds    = data[7:0];
      default: ;
    endcase
  endfunction

  // Pick the winner of one frame and advance the debounce state.
  function automatic cvd_pkg::result_t debounce_frame(frame_t s);
    cvd_pkg::result_t r;
    logic [1:0]       lead;
    logic [15:0]      top;
    logic [15:0]      thr;
    logic [5:0]       fr;
    cvd_pkg::kind_t   k;
    lead = 2'd0;
    top  = s[0];
    for (int i = 1; i < cvd_pkg::MAX_LABELS; i++) begin
      if (s[i] > top) begin
        top  = s[i];
        lead = 2'(i);
      end
    end
    lane_setting(lead, k, thr, fr);
    r = '0;
    r.winning_label = lead;
    r.winning_score = top;
    if (top < thr) begin
      run_len = '0;
    end else begin
      if ({1'b0, lead} == cand_label) begin
        if (run_len != cvd_pkg::RUN_MAX) run_len++;
      end else begin
        cand_label = {1'b0, lead};
        run_len    = 6'd1;
      end
      if (run_len >= fr) begin
        if (held_label != cand_label) begin
          held_label = cand_label;
          if (k != cvd_pkg::KIND_DEFAULT) begin
            r.fired      = 1'b1;
            r.event_kind = 2'(k - cvd_pkg::KIND_TAP);
          end
        end
        run_len = fr;
      end
    end
    r.active_label = held_label;
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (pacing_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A frame led by one label, above its threshold unless a dip is asked.
  function automatic frame_t shaped_frame(logic [1:0] lead, bit dip);
    frame_t         s;
    cvd_pkg::kind_t k;
    logic [15:0]    thr;
    logic [5:0]     fr;
    logic [15:0]    top;
    lane_setting(lead, k, thr, fr);
    if (dip && thr != 0) top = 16'($urandom_range(0, thr - 1));
    else if ($urandom_range(0, 9) == 0 || thr > 16'd32768) top = 16'($urandom_range(thr, 65535));
    else top = 16'($urandom_range(thr, 32768));
    for (int j = 0; j < cvd_pkg::MAX_LABELS; j++) begin
      if (j == lead || $urandom_range(0, 15) == 0) s[j] = top;
      else s[j] = (top == 0) ? 16'd0 : 16'($urandom_range(0, top - 1));
    end
    return s;
  endfunction

  function automatic frame_t noise_frame();
    frame_t s;
    for (int j = 0; j < cvd_pkg::MAX_LABELS; j++) begin
      s[j] = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                  : 16'($urandom_range(0, 32768));
    end
    return s;
  endfunction

  function automatic stim_row_t frame_row(logic [15:0] s0, logic [15:0] s1,
                                          logic [15:0] s2, logic [15:0] s3);
    stim_row_t row;
    row.kind     = ROW_FRAME;
    row.scores   = {s3, s2, s1, s0};
    row.reg_idx  = '0;
    row.reg_data = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                                          logic [15:0] s3, logic [1:0] wl, logic [15:0] ws);
    stim_row_t row;
    row = frame_row(s0, s1, s2, s3);
    row.typed = 1'b1;
    row.want.winning_label = wl;
    row.want.winning_score = ws;
    row.want.active_label  = cvd_pkg::LABEL_NONE;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic [2:0] idx, logic [15:0] data);
    stim_row_t row;
    row = frame_row('0, '0, '0, '0);
    row.kind     = ROW_WRITE;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Present one frame and hold it until the transfer, then log its expectation.
  task automatic send_frame(frame_t s, bit typed, cvd_pkg::result_t want);
    int               gap;
    cvd_pkg::result_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    score_0  <= s[0];
    score_1  <= s[1];
    score_2  <= s[2];
    score_3  <= s[3];
    do @(posedge clk); while (!in_ready);
    predicted = debounce_frame(s);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stop sending and let every pending result come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    mirror_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Each phase rewrites every register; the first phases take the extremes.
  task automatic program_phase(int p);
    logic [15:0] thr_pick [3];
    logic [5:0]  fr_pick [4];
    logic [7:0]  kinds;
    for (int j = 0; j < 3; j++) begin
      case (p)
        0:       thr_pick[j] = 16'd0;
        1:       thr_pick[j] = 16'd32768;
        2:       thr_pick[j] = 16'($urandom_range(0, 65535));
        default: thr_pick[j] = 16'($urandom_range(0, 32768));
      endcase
    end
    for (int j = 0; j < 4; j++) begin
      case (p)
        0:       fr_pick[j] = 6'd0;
        1:       fr_pick[j] = 6'd63;
        2:       fr_pick[j] = 6'($urandom_range(0, 63));
        default: fr_pick[j] = 6'($urandom_range(0, 6));
      endcase
    end
    case (p)
      0:       kinds = 8'h1B;
      1:       kinds = 8'hE4;
      2:       kinds = 8'hFF;
      3:       kinds = 8'h00;
      default: kinds = 8'($urandom_range(0, 255));
    endcase
    write_register(cvd_pkg::REG_DEFAULT_THRESHOLD, thr_pick[0]);
    write_register(cvd_pkg::REG_TAP_THRESHOLD, thr_pick[1]);
    write_register(cvd_pkg::REG_SHAKE_THRESHOLD, thr_pick[2]);
    // Upper data bits are random so the width masking gets exercised.
    write_register(cvd_pkg::REG_DEFAULT_FRAMES, (16'($urandom) & 16'hFFC0) | fr_pick[0]);
    write_register(cvd_pkg::REG_TAP_FRAMES, (16'($urandom) & 16'hFFC0) | fr_pick[1]);
    write_register(cvd_pkg::REG_SHAKE_FRAMES, (16'($urandom) & 16'hFFC0) | fr_pick[2]);
    write_register(cvd_pkg::REG_IDLE_FRAMES, (16'($urandom) & 16'hFFC0) | fr_pick[3]);
    write_register(cvd_pkg::REG_LABEL_KINDS, (16'($urandom) & 16'hFF00) | kinds);
  endtask

  // Output side: the receiver stalls at random.
  initial begin : rx_pacing
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    cvd_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, winning_score", winning_score, 0);
      end else begin
        want = pending_results.pop_front();
        if (fired !== want.fired) report_mismatch("fired", fired, want.fired);
        if (event_kind !== want.event_kind)
          report_mismatch("event_kind", event_kind, want.event_kind);
        if (winning_label !== want.winning_label)
          report_mismatch("winning_label", winning_label, want.winning_label);
        if (winning_score !== want.winning_score)
          report_mismatch("winning_score", winning_score, want.winning_score);
        if (active_label !== want.active_label)
          report_mismatch("active_label", active_label, want.active_label);
      end
    end
  end

  initial begin : stimulus
    stim_row_t      row;
    int             sent;
    int             len;
    logic [1:0]     lead;
    cvd_pkg::kind_t k;
    logic [15:0]    thr;
    logic [5:0]     fr;

    cfg_mirror.default_thr    = 16'd22938;
    cfg_mirror.tap_thr        = 16'd32113;
    cfg_mirror.shake_thr      = 16'd27853;
    cfg_mirror.default_frames = 6'd5;
    cfg_mirror.tap_frames     = 6'd18;
    cfg_mirror.shake_frames   = 6'd3;
    cfg_mirror.idle_frames    = 6'd4;
    cfg_mirror.label_kinds    = 8'd0;
    held_label = cvd_pkg::LABEL_NONE;
    cand_label = cvd_pkg::LABEL_NONE;
    run_len    = '0;

    // Out of reset: all default kind, nothing can be accepted yet.
    directed_rows.push_back(typed_row(16'd0, 16'd0, 16'd0, 16'd0, 2'd0, 16'd0));
    directed_rows.push_back(typed_row(16'd32768, 16'd32768, 16'd32768, 16'd32768,
                                      2'd0, 16'd32768));
    directed_rows.push_back(typed_row(16'd32768, 16'd32768, 16'd32768, 16'd65535,
                                      2'd3, 16'd65535));
    directed_rows.push_back(typed_row(16'd100, 16'd30000, 16'd30000, 16'd5, 2'd1, 16'd30000));
    // One label of each kind, short runs, a masked run length.
    directed_rows.push_back(write_row(cvd_pkg::REG_LABEL_KINDS, 16'hFFE4));
    directed_rows.push_back(write_row(cvd_pkg::REG_TAP_FRAMES, 16'hFFC1));
    directed_rows.push_back(write_row(cvd_pkg::REG_SHAKE_FRAMES, 16'd0));
    directed_rows.push_back(write_row(cvd_pkg::REG_IDLE_FRAMES, 16'd2));
    directed_rows.push_back(write_row(cvd_pkg::REG_DEFAULT_FRAMES, 16'd2));
    // Tap at exactly its threshold fires; one code below only clears the run.
    directed_rows.push_back(frame_row(16'd0, 16'd32113, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd0, 16'd32112, 16'd0, 16'd0));
    // Shake with a zero run length fires on its first frame.
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd27853, 16'd0));
    // Idle threshold is fixed at one half.
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd0, 16'd16383));
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd0, 16'd16384));
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd0, 16'd16384));
    // Default kind takes over without an event.
    directed_rows.push_back(frame_row(16'd40000, 16'd0, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd40000, 16'd0, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd22937, 16'd0, 16'd0, 16'd22937));
    // Threshold extremes, including codes above one.
    directed_rows.push_back(write_row(cvd_pkg::REG_DEFAULT_THRESHOLD, 16'd0));
    directed_rows.push_back(write_row(cvd_pkg::REG_TAP_THRESHOLD, 16'd32768));
    directed_rows.push_back(write_row(cvd_pkg::REG_SHAKE_THRESHOLD, 16'hFFFF));
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd0, 16'd32767, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd0, 16'd65535, 16'd0, 16'd0));
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd65534, 16'd0));
    directed_rows.push_back(frame_row(16'd0, 16'd0, 16'd65535, 16'd0));

    while (rst) @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_register(row.reg_idx, row.reg_data);
      else send_frame(row.scores, row.typed, row.want);
    end

    // Random part: mostly runs of one leading label, some noise frames.
    for (int p = 0; p < PHASES; p++) begin
      program_phase(p);
      pacing_off = (p == 3 || p == 7);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          send_frame(noise_frame(), 1'b0, '0);
          sent++;
        end else begin
          lead = 2'($urandom_range(0, 3));
          lane_setting(lead, k, thr, fr);
          len = $urandom_range(1, fr + 3);
          for (int j = 0; j < len && sent < ITEMS_PER_PHASE; j++) begin
            send_frame(shaped_frame(lead, $urandom_range(0, 11) == 0), 1'b0, '0);
            sent++;
          end
        end
      end
    end
    pacing_off = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still pending", pending_results.size(), 0);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
